// ===== hdl/pti_pkg.sv =====
package pti_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int DQ_W       = 64;
    localparam int DCNT_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 2'd3;

    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_POS   = 2'd2;

    localparam logic [DCNT_W-1:0] DIV_LEN_MOD = 7'd33;
    localparam logic [DCNT_W-1:0] DIV_LEN_IDX = 7'd41;
    localparam logic [DCNT_W-1:0] DIV_LEN_INT = 7'd64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_POINTS);

endpackage

// ===== hdl/periodic_table_interpolator_top.sv =====
// Periodic function generator over a table of up to 256 signed Q16.16 points. A write item
// (start with opcode 1) stores one point and its result appears in the cycle after the transfer.
// An evaluate item wraps the argument into [range_low, range_high) and returns the left point
// of its section (step mode) or the linear interpolation to the next point (smooth mode). All
// three divisions run on one shared restoring divider at one quotient bit per cycle. A single
// point or zero period returns point 0 without dividing, and a negative period returns zero
// with range status.
// Busy stays high until the result cycle; the result is shown on o_valid for exactly one cycle
// and a new start may be taken in that same cycle. There is no way to hold results off.
module periodic_table_interpolator_top
    import pti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_opcode,
    input  logic [VALUE_W-1:0]   i_argument,
    input  logic [ADDR_W-1:0]    i_point_position,
    input  logic [VALUE_W-1:0]   i_point_value,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_wr_data,
    output logic                 o_valid,
    output logic [VALUE_W-1:0]   o_result_value,
    output logic [1:0]           o_status
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_MOD   = 14'b00000000000010,
        S_MUL   = 14'b00000000000100,
        S_IDX   = 14'b00000000001000,
        S_RDL   = 14'b00000000010000,
        S_LEFT  = 14'b00000000100000,
        S_RDR   = 14'b00000001000000,
        S_RIGHT = 14'b00000010000000,
        S_MLO   = 14'b00000100000000,
        S_MHI   = 14'b00001000000000,
        S_MACC  = 14'b00010000000000,
        S_QDIV  = 14'b00100000000000,
        S_RD0   = 14'b01000000000000,
        S_OUT0  = 14'b10000000000000
    } t_state;

    t_state               r_state;

    logic [VALUE_W-1:0]   r_range_low;
    logic [VALUE_W-1:0]   r_range_high;
    logic                 r_smooth;
    logic [COUNT_W-1:0]   r_points;

    logic [VALUE_W-1:0]   r_mem [MAX_POINTS];
    logic [VALUE_W-1:0]   r_rd_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;

    logic [VALUE_W-1:0]   r_period;
    logic                 r_a_neg;
    logic [COUNT_W-1:0]   r_sections;
    logic [COUNT_W-1:0]   r_eff;
    logic [ADDR_W-1:0]    r_idx;
    logic [VALUE_W-1:0]   r_num;
    logic [VALUE_W-1:0]   r_left;
    logic                 r_dneg;
    logic [VALUE_W:0]     r_mag;
    logic [DQ_W-1:0]      r_acc;
    logic [47:0]          r_ph;

    logic [DQ_W-1:0]      r_dq;
    logic [VALUE_W-1:0]   r_drem;
    logic [DCNT_W-1:0]    r_dcnt;

    logic                 r_valid;
    logic [VALUE_W-1:0]   r_result;
    logic [1:0]           r_status;

    logic                 accept;
    logic [COUNT_W-1:0]   eff_count;
    logic [COUNT_W-1:0]   sections_w;
    logic signed [VALUE_W:0] period_w;
    logic signed [VALUE_W:0] diff_a;
    logic [VALUE_W:0]     div_trial;
    logic [VALUE_W:0]     div_diff;
    logic                 div_ge;
    logic [VALUE_W-1:0]   wrap_r;
    logic [40:0]          prod_w;
    logic signed [VALUE_W:0] delta_w;
    logic [48:0]          mlo_w;
    logic [48:0]          mhi_w;
    logic [DQ_W-1:0]      dividend_int;

    assign accept = i_start && !o_busy;

    always_comb begin
        if (r_points == '0) begin
            eff_count = COUNT_W'(1);
        end else if (r_points > COUNT_MAX) begin
            eff_count = COUNT_MAX;
        end else begin
            eff_count = r_points;
        end
    end

    assign sections_w = r_smooth ? eff_count - COUNT_W'(1) : eff_count;
    assign period_w   = $signed({r_range_high[VALUE_W-1], r_range_high})
                      - $signed({r_range_low[VALUE_W-1], r_range_low});
    assign diff_a     = $signed({i_argument[VALUE_W-1], i_argument})
                      - $signed({r_range_low[VALUE_W-1], r_range_low});

    assign div_trial = {r_drem, r_dq[DQ_W-1]};
    assign div_diff  = div_trial - {1'b0, r_period};
    assign div_ge    = div_trial >= {1'b0, r_period};

    assign wrap_r  = (r_a_neg && r_drem != '0) ? r_period - r_drem : r_drem;
    assign prod_w  = 41'(wrap_r) * 41'(r_sections);
    assign delta_w = $signed({r_rd_data[VALUE_W-1], r_rd_data})
                   - $signed({r_left[VALUE_W-1], r_left});
    assign mlo_w   = 49'(r_mag) * 49'(r_num[15:0]);
    assign mhi_w   = 49'(r_mag) * 49'(r_num[31:16]);
    assign dividend_int = r_acc + {r_ph, 16'b0};

    assign mem_we = accept && i_opcode == OP_WRITE && {1'b0, i_point_position} < eff_count;

    always_comb begin
        unique case (r_state)
            S_RDL:   rd_addr = r_dq[ADDR_W-1:0];
            S_RDR:   rd_addr = r_idx + ADDR_W'(1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_point_position] <= i_point_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= VALUE_W'(65536);
            r_smooth     <= 1'b0;
            r_points     <= COUNT_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:     r_range_low  <= i_cfg_wr_data;
                CFG_RANGE_HIGH:    r_range_high <= i_cfg_wr_data;
                CFG_SMOOTH_MODE:   r_smooth     <= i_cfg_wr_data[0];
                CFG_POINTS_IN_USE: r_points     <= i_cfg_wr_data[COUNT_W-1:0];
                default:           r_points     <= r_points;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_period   <= period_w[VALUE_W-1:0];
                        r_a_neg    <= diff_a[VALUE_W];
                        r_sections <= sections_w;
                        r_eff      <= eff_count;
                        if (i_opcode == OP_WRITE) begin
                            r_valid  <= 1'b1;
                            r_result <= '0;
                            r_status <= mem_we ? ST_OK : ST_POS;
                        end else if (period_w[VALUE_W]) begin
                            r_valid  <= 1'b1;
                            r_result <= '0;
                            r_status <= ST_RANGE;
                        end else if (eff_count == COUNT_W'(1) || period_w == '0) begin
                            r_state <= S_RD0;
                        end else begin
                            r_dq    <= {diff_a[VALUE_W] ? 33'(-diff_a) : 33'(diff_a), 31'b0};
                            r_drem  <= '0;
                            r_dcnt  <= DIV_LEN_MOD;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD, S_IDX, S_QDIV: begin
                    r_drem <= div_ge ? div_diff[VALUE_W-1:0] : div_trial[VALUE_W-1:0];
                    r_dq   <= {r_dq[DQ_W-2:0], div_ge};
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        if (r_state == S_MOD) begin
                            r_state <= S_MUL;
                        end else if (r_state == S_IDX) begin
                            r_state <= S_RDL;
                        end else begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                            r_status <= ST_OK;
                            r_result <= r_dneg
                                ? r_left - {r_dq[VALUE_W-2:0], div_ge}
                                : r_left + {r_dq[VALUE_W-2:0], div_ge};
                        end
                    end
                end
                S_MUL: begin
                    r_dq    <= {prod_w, 23'b0};
                    r_drem  <= '0;
                    r_dcnt  <= DIV_LEN_IDX;
                    r_state <= S_IDX;
                end
                S_RDL: begin
                    r_idx   <= r_dq[ADDR_W-1:0];
                    r_num   <= r_drem;
                    r_state <= S_LEFT;
                end
                S_LEFT: begin
                    r_left <= r_rd_data;
                    if (!r_smooth || {1'b0, r_idx} + COUNT_W'(1) >= r_eff) begin
                        r_valid  <= 1'b1;
                        r_result <= r_rd_data;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_RDR;
                    end
                end
                S_RDR: begin
                    r_state <= S_RIGHT;
                end
                S_RIGHT: begin
                    r_dneg  <= delta_w[VALUE_W];
                    r_mag   <= delta_w[VALUE_W] ? 33'(-delta_w) : 33'(delta_w);
                    r_state <= S_MLO;
                end
                S_MLO: begin
                    r_acc   <= 64'(mlo_w);
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_ph    <= mhi_w[47:0];
                    r_state <= S_MACC;
                end
                S_MACC: begin
                    r_dq    <= dividend_int;
                    r_drem  <= '0;
                    r_dcnt  <= DIV_LEN_INT;
                    r_state <= S_QDIV;
                end
                S_RD0: begin
                    r_state <= S_OUT0;
                end
                S_OUT0: begin
                    r_valid  <= 1'b1;
                    r_result <= r_rd_data;
                    r_status <= ST_OK;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_valid        = r_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;

    a_valid_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state != S_IDLE || accept))
        else $error("Result strobe without a transfer or work in progress.");

    a_eval_progresses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_EVAL) |=> (r_state != S_IDLE || r_valid))
        else $error("Evaluate transfer neither started work nor produced a result.");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_RANGE) |-> r_result == '0)
        else $error("Negative period result is not zero.");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD || r_state == S_IDX || r_state == S_QDIV) |-> r_dcnt != '0)
        else $error("Divider running with an empty step count.");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE && !$past(r_state == S_RDR)))
        else $error("Table write while an evaluation is in progress.");

endmodule
